@@ rtl/core/cal_pkg.sv @@
`default_nettype none

package cal_pkg;

  // Number of element slots, the widths that follow from it, and the element width.
  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  // Operation codes.
  localparam logic [3:0] OP_INS_BEFORE = 4'd0;
  localparam logic [3:0] OP_INS_AFTER  = 4'd1;
  localparam logic [3:0] OP_DELETE     = 4'd2;
  localparam logic [3:0] OP_PREV       = 4'd3;
  localparam logic [3:0] OP_NEXT       = 4'd4;
  localparam logic [3:0] OP_FIRST      = 4'd5;
  localparam logic [3:0] OP_LAST       = 4'd6;
  localparam logic [3:0] OP_RD_CUR     = 4'd7;
  localparam logic [3:0] OP_WR_CUR     = 4'd8;
  localparam logic [3:0] OP_RD_IDX     = 4'd9;
  localparam logic [3:0] OP_WR_IDX     = 4'd10;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_STUCK = 3'd4;

  // Write and read request into the element memory.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

@@ rtl/core/cal_ram.sv @@
`default_nettype none

// Element store: one write port and one read port, read data registered.
module cal_ram (
  input  wire logic                     clk_i,
  input  wire cal_pkg::ram_req_t        req_i,
  output logic [cal_pkg::DataW-1:0]     rdata_o
);

  logic [cal_pkg::DataW-1:0] mem [cal_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cursor_array_list_core.sv @@
`default_nettype none

// Ordered list of 32-bit elements kept in a 256-entry single-port-pair memory,
// with a cursor on the current element. Each accepted beat carries one
// operation and returns exactly one result beat with the data read (zero when
// nothing is read), a status code, the element count and the cursor after the
// operation. One beat is worked on at a time. An insert or a delete moves
// every element between the gap and the end of the list: the memory has one
// read and one write port, and the shift streams one element per cycle
// through them. A finished result waits in the output register while the
// next input beat is already being taken. The memory needs no clearing after
// reset; only positions below the count are ever read.
module cursor_array_list_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [3:0]                 operation_i,
  input  wire logic signed [31:0]         value_i,
  input  wire logic [7:0]                 index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [31:0]              data_o,
  output logic [2:0]                      status_o,
  output logic [8:0]                      element_count_o,
  output logic [7:0]                      cursor_pos_o
);

  localparam int unsigned AW = cal_pkg::AddrW;
  localparam int unsigned CW = cal_pkg::CntW;
  localparam int unsigned DW = cal_pkg::DataW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;  // read data returning
  localparam logic [2:0] S_UP   = 3'd2;  // tail moving up one slot
  localparam logic [2:0] S_WRV  = 3'd3;  // new element into the gap
  localparam logic [2:0] S_DN   = 3'd4;  // tail moving down one slot
  localparam logic [2:0] S_FIN  = 3'd5;  // result ready for the output

  // Memory work an accepted beat needs.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_INS   = 3'd3;
  localparam logic [2:0] ACT_DEL   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] lim_q, lim_d;
  logic [DW-1:0] val_q;
  logic [DW-1:0] data_q, data_d;
  logic [2:0]    status_q;
  logic          out_valid_q;
  logic [DW-1:0] out_data_q;
  logic [2:0]    out_status_q;
  logic [CW-1:0] out_count_q;
  logic [AW-1:0] out_cursor_q;

  logic          accept;
  logic          out_free;
  logic          empty;
  logic          full;
  logic [2:0]    acc_status;
  logic [2:0]    acc_act;
  logic [CW-1:0] acc_count;
  logic [AW-1:0] acc_cursor;
  logic [AW-1:0] acc_gap;
  logic [CW-1:0] cur_ext;
  logic [CW-1:0] idx_ext;

  cal_pkg::ram_req_t   ram_req;
  logic [DW-1:0]       ram_rdata;

  cal_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign empty   = (count_q == '0);
  assign full    = (count_q == CW'(cal_pkg::Capacity));
  assign cur_ext = {1'b0, cursor_q};
  assign idx_ext = {1'b0, index_i};

  // Decode the incoming operation against the current count and cursor. The
  // new count and cursor are known at once; only the memory work takes time.
  always_comb begin
    acc_status = cal_pkg::ST_OK;
    acc_act    = ACT_NONE;
    acc_count  = count_q;
    acc_cursor = cursor_q;
    acc_gap    = cursor_q;
    unique case (operation_i)
      cal_pkg::OP_INS_BEFORE: begin
        if (full) begin
          acc_status = cal_pkg::ST_FULL;
        end else begin
          acc_act   = ACT_INS;
          acc_count = count_q + CW'(1);
        end
      end
      cal_pkg::OP_INS_AFTER: begin
        if (full) begin
          acc_status = cal_pkg::ST_FULL;
        end else begin
          acc_act   = ACT_INS;
          acc_count = count_q + CW'(1);
          if (empty) begin
            acc_gap    = '0;
            acc_cursor = '0;
          end else begin
            acc_gap    = cursor_q + AW'(1);
            acc_cursor = cursor_q + AW'(1);
          end
        end
      end
      cal_pkg::OP_DELETE: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else begin
          acc_act   = ACT_DEL;
          acc_count = count_q - CW'(1);
          // Stepping back off the old last element keeps the cursor valid.
          if ((cur_ext >= count_q - CW'(1)) && (cursor_q != '0)) begin
            acc_cursor = cursor_q - AW'(1);
          end
        end
      end
      cal_pkg::OP_PREV: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else if (cursor_q == '0) begin
          acc_status = cal_pkg::ST_STUCK;
        end else begin
          acc_cursor = cursor_q - AW'(1);
        end
      end
      cal_pkg::OP_NEXT: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else if (cur_ext + CW'(1) >= count_q) begin
          acc_status = cal_pkg::ST_STUCK;
        end else begin
          acc_cursor = cursor_q + AW'(1);
        end
      end
      cal_pkg::OP_FIRST: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else begin
          acc_cursor = '0;
        end
      end
      cal_pkg::OP_LAST: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else begin
          acc_cursor = AW'(count_q - CW'(1));
        end
      end
      cal_pkg::OP_RD_CUR: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else begin
          acc_act = ACT_READ;
        end
      end
      cal_pkg::OP_WR_CUR: begin
        if (empty) begin
          acc_status = cal_pkg::ST_EMPTY;
        end else begin
          acc_act = ACT_WRITE;
        end
      end
      cal_pkg::OP_RD_IDX: begin
        if (idx_ext >= count_q) begin
          acc_status = cal_pkg::ST_RANGE;
        end else begin
          acc_act = ACT_READ;
        end
      end
      cal_pkg::OP_WR_IDX: begin
        if (idx_ext >= count_q) begin
          acc_status = cal_pkg::ST_RANGE;
        end else begin
          acc_act = ACT_WRITE;
        end
      end
      default: begin
        // Unused codes leave everything as it is and report success.
      end
    endcase
  end

  // Sequencer and memory port control. Shifts read one slot ahead of the
  // write, so a read never targets a slot that is being written, and every
  // slot is read before it is overwritten.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cursor_d      = cursor_q;
    ptr_d         = ptr_q;
    lim_d         = lim_q;
    data_d        = data_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr_q + AW'(1);
    ram_req.wdata = ram_rdata;
    ram_req.re    = 1'b0;
    ram_req.raddr = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          count_d  = acc_count;
          cursor_d = acc_cursor;
          data_d   = '0;
          lim_d    = acc_gap;
          state_d  = S_FIN;
          unique case (acc_act)
            ACT_READ: begin
              ram_req.re    = 1'b1;
              ram_req.raddr = (operation_i == cal_pkg::OP_RD_IDX) ? index_i : cursor_q;
              state_d       = S_RDW;
            end
            ACT_WRITE: begin
              ram_req.we    = 1'b1;
              ram_req.waddr = (operation_i == cal_pkg::OP_WR_IDX) ? index_i : cursor_q;
              ram_req.wdata = value_i;
            end
            ACT_INS: begin
              if (acc_gap == AW'(count_q)) begin
                // Appending at the end: nothing has to move.
                state_d = S_WRV;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = AW'(count_q - CW'(1));
                ptr_d         = AW'(count_q - CW'(1));
                state_d       = S_UP;
              end
            end
            ACT_DEL: begin
              if (cur_ext + CW'(1) < count_q) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cursor_q + AW'(1);
                ptr_d         = cursor_q + AW'(1);
                lim_d         = AW'(count_q - CW'(1));
                state_d       = S_DN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDW: begin
        data_d  = ram_rdata;
        state_d = S_FIN;
      end
      S_UP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_q + AW'(1);
        ram_req.wdata = ram_rdata;
        if (ptr_q == lim_q) begin
          state_d = S_WRV;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_q - AW'(1);
          ptr_d         = ptr_q - AW'(1);
        end
      end
      S_WRV: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = lim_q;
        ram_req.wdata = val_q;
        state_d       = S_FIN;
      end
      S_DN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_q - AW'(1);
        ram_req.wdata = ram_rdata;
        if (ptr_q == lim_q) begin
          state_d = S_FIN;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ptr_q + AW'(1);
          ptr_d         = ptr_q + AW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    lim_q  <= lim_d;
    data_q <= data_d;
    if (accept) begin
      val_q    <= value_i;
      status_q <= acc_status;
    end
    if ((state_q == S_FIN) && out_free) begin
      out_data_q   <= data_q;
      out_status_q <= status_q;
      out_count_q  <= count_q;
      out_cursor_q <= cursor_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_o          = out_data_q;
  assign status_o        = out_status_q;
  assign element_count_o = out_count_q;
  assign cursor_pos_o    = out_cursor_q;

endmodule

`default_nettype wire

@@ test/cursor_array_list_core_tb.sv @@
`timescale 1ns / 100ps

// Mirror of the list: it keeps its own copy of the element slots, the count
// and the cursor, and it queues the result beat that each accepted operation
// must produce.
class list_mirror;
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  status;
    logic [8:0]  count;
    logic [7:0]  cursor;
  } list_result_t;

  logic [31:0]  slots [cal_pkg::Capacity];
  logic [8:0]   count_q;
  logic [7:0]   cursor_q;
  list_result_t awaited [$];
  int unsigned  faults;

  function new();
    count_q  = '0;
    cursor_q = '0;
    faults   = 0;
  endfunction

  function int unsigned held();
    return count_q;
  endfunction

  function int unsigned awaiting();
    return awaited.size();
  endfunction

  function void flag(string msg);
    if (faults < 10) $display("%s", msg);
    faults++;
  endfunction

  // Applies one accepted operation and queues the result it must return.
  function void note_beat(logic [3:0] op, logic [31:0] val, logic [7:0] idx);
    list_result_t r;
    int           n;
    int           c;
    int           i;
    n = count_q;
    c = cursor_q;
    r.data   = '0;
    r.status = cal_pkg::ST_OK;
    case (op)
      cal_pkg::OP_INS_BEFORE: begin
        if (n >= cal_pkg::Capacity) begin
          r.status = cal_pkg::ST_FULL;
        end else begin
          for (i = n; i > c; i--) slots[i] = slots[i-1];
          slots[c] = val;
          n++;
        end
      end
      cal_pkg::OP_INS_AFTER: begin
        if (n >= cal_pkg::Capacity) begin
          r.status = cal_pkg::ST_FULL;
        end else if (n == 0) begin
          c = 0;
          slots[0] = val;
          n++;
        end else begin
          for (i = n; i > c + 1; i--) slots[i] = slots[i-1];
          c++;
          slots[c] = val;
          n++;
        end
      end
      cal_pkg::OP_DELETE: begin
        if (n == 0) begin
          r.status = cal_pkg::ST_EMPTY;
        end else begin
          for (i = c; i + 1 < n; i++) slots[i] = slots[i+1];
          n--;
          if (c >= n && c > 0) c--;
        end
      end
      cal_pkg::OP_PREV: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else if (c == 0) r.status = cal_pkg::ST_STUCK;
        else c--;
      end
      cal_pkg::OP_NEXT: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else if (c + 1 >= n) r.status = cal_pkg::ST_STUCK;
        else c++;
      end
      cal_pkg::OP_FIRST: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else c = 0;
      end
      cal_pkg::OP_LAST: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else c = n - 1;
      end
      cal_pkg::OP_RD_CUR: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else r.data = slots[c];
      end
      cal_pkg::OP_WR_CUR: begin
        if (n == 0) r.status = cal_pkg::ST_EMPTY;
        else slots[c] = val;
      end
      cal_pkg::OP_RD_IDX: begin
        if (idx >= n) r.status = cal_pkg::ST_RANGE;
        else r.data = slots[idx];
      end
      cal_pkg::OP_WR_IDX: begin
        if (idx >= n) r.status = cal_pkg::ST_RANGE;
        else slots[idx] = val;
      end
      default: ;
    endcase
    count_q  = n[8:0];
    cursor_q = c[7:0];
    r.count  = count_q;
    r.cursor = cursor_q;
    awaited.push_back(r);
  endfunction

  // Compares one accepted result beat with the oldest queued result.
  function void check_beat(logic [31:0] data, logic [2:0] status, logic [8:0] cnt,
                           logic [7:0] cur);
    list_result_t w;
    if (awaited.size() == 0) begin
      flag($sformatf("result beat with nothing pending: data %h status %0d count %0d cursor %0d",
                     data, status, cnt, cur));
      return;
    end
    w = awaited.pop_front();
    if (w.data !== data || w.status !== status || w.count !== cnt || w.cursor !== cur) begin
      flag($sformatf({"result mismatch: expected data %h status %0d count %0d cursor %0d,",
                      " got data %h status %0d count %0d cursor %0d"},
                     w.data, w.status, w.count, w.cursor, data, status, cnt, cur));
    end
  endfunction
endclass

module cursor_array_list_core_tb;

  // Codes 11 to 15 are not operations; the block must answer them with ok and no change.
  localparam logic [3:0] OP_UNUSED_LO = 4'd11;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // Random beats in total, and how many of them at the end run with no idling at all.
  localparam int RandomBeats = 1800;
  localparam int QuietBeats  = 200;

  // This outlasts a full-list shift, so it covers the last result and then some.
  localparam int DrainCycles = 600;

  // Generous bound: every beat paying a full shift, the longest input gap and output
  // stall, taken several times over.
  localparam longint LimitNs = 64'd3_000_000 * 12;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [3:0]         operation_i = '0;
  logic signed [31:0] value_i     = '0;
  logic [7:0]         index_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] data_o;
  logic [2:0]         status_o;
  logic [8:0]         element_count_o;
  logic [7:0]         cursor_pos_o;

  // These two switch the random idling of the sender and the receiver.
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int stall_left = 0;

  list_mirror mirror = new();

  cursor_array_list_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .index_i         (index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_o          (data_o),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .cursor_pos_o    (cursor_pos_o)
  );

  always #6 clk_i = ~clk_i;

  // The receiver stalls in bursts. A burst starts with the stall raised for this cycle
  // and stall_left holding the extra cycles still to come.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Every result beat that is taken is checked against the mirror. Signals are read
  // in the active region of the edge, so they still hold their values from before it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_beat(data_o, status_o, element_count_o, cursor_pos_o);
    end
  end

  // Offers one operation beat and waits until the block takes it. A random idle gap may
  // come first; the valid is only lowered for such a gap, so it never sees two
  // assignments in one step.
  task automatic send_beat(logic [3:0] op, logic [31:0] val, logic [7:0] idx);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    index_i     <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_beat(op, val, idx);
  endtask

  // Growing phases favor inserts so the list fills up to its capacity; shrinking
  // phases favor deletes so it drains down to empty again.
  function automatic logic [3:0] pick_op(bit growing);
    logic [3:0]  others [8];
    int unsigned r;
    others = '{cal_pkg::OP_PREV, cal_pkg::OP_NEXT, cal_pkg::OP_FIRST, cal_pkg::OP_LAST,
               cal_pkg::OP_RD_CUR, cal_pkg::OP_WR_CUR, cal_pkg::OP_RD_IDX,
               cal_pkg::OP_WR_IDX};
    r = $urandom_range(0, 99);
    if (r < 2) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (growing) begin
      if (r < 32) return cal_pkg::OP_INS_BEFORE;
      if (r < 60) return cal_pkg::OP_INS_AFTER;
      if (r < 66) return cal_pkg::OP_DELETE;
    end else begin
      if (r < 8)  return cal_pkg::OP_INS_BEFORE;
      if (r < 16) return cal_pkg::OP_INS_AFTER;
      if (r < 50) return cal_pkg::OP_DELETE;
    end
    return others[r % 8];
  endfunction

  // Element values lean toward the signed extremes, zero and minus one now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Indexes mostly land inside the list, the rest anywhere in the 8-bit range.
  function automatic logic [7:0] pick_index();
    if (mirror.held() > 0 && $urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(0, mirror.held() - 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    bit growing;
    growing = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Everything that needs an element fails on the empty list, and indexed access
    // is out of range at any index. Unused codes simply answer ok.
    send_beat(cal_pkg::OP_DELETE,    32'h0, 8'd0);
    send_beat(cal_pkg::OP_PREV,      32'h0, 8'd0);
    send_beat(cal_pkg::OP_NEXT,      32'h0, 8'd0);
    send_beat(cal_pkg::OP_FIRST,     32'h0, 8'd0);
    send_beat(cal_pkg::OP_LAST,      32'h0, 8'd0);
    send_beat(cal_pkg::OP_RD_CUR,    32'h0, 8'd0);
    send_beat(cal_pkg::OP_WR_CUR,    32'hffff_ffff, 8'd0);
    send_beat(cal_pkg::OP_RD_IDX,    32'h0, 8'd0);
    send_beat(cal_pkg::OP_WR_IDX,    32'h1234_5678, 8'd255);
    send_beat(OP_UNUSED_LO,          32'hffff_ffff, 8'd255);
    send_beat(OP_UNUSED_HI,          32'h0, 8'd0);

    // Build a short list: insert-after on an empty list lands in slot zero, insert-before
    // shifts the tail, and the insert-afters that follow land mid-list and shift it too.
    send_beat(cal_pkg::OP_INS_AFTER,  32'h8000_0000, 8'd0);
    send_beat(cal_pkg::OP_INS_BEFORE, 32'h7fff_ffff, 8'd0);
    send_beat(cal_pkg::OP_INS_AFTER,  32'hffff_ffff, 8'd0);
    send_beat(cal_pkg::OP_INS_AFTER,  32'h0000_0000, 8'd0);

    // Moves, including both blocked moves at the ends of the list.
    send_beat(cal_pkg::OP_PREV,  32'h0, 8'd0);
    send_beat(cal_pkg::OP_FIRST, 32'h0, 8'd0);
    send_beat(cal_pkg::OP_PREV,  32'h0, 8'd0);
    send_beat(cal_pkg::OP_LAST,  32'h0, 8'd0);
    send_beat(cal_pkg::OP_NEXT,  32'h0, 8'd0);

    // Access at the cursor and by index, with one index just past the end.
    send_beat(cal_pkg::OP_WR_CUR, 32'h5a5a_a5a5, 8'd0);
    send_beat(cal_pkg::OP_RD_CUR, 32'h0, 8'd0);
    send_beat(cal_pkg::OP_WR_IDX, 32'h8000_0001, 8'd0);
    send_beat(cal_pkg::OP_RD_IDX, 32'h0, 8'd3);
    send_beat(cal_pkg::OP_RD_IDX, 32'h0, 8'd4);

    // Deleting the last element steps the cursor back.
    send_beat(cal_pkg::OP_DELETE, 32'h0, 8'd0);

    // Random phase. The list is driven to full and back to empty, lingering a little
    // at each end so that full inserts and empty-list operations come up as well.
    for (int k = 0; k < RandomBeats; k++) begin
      if (k == RandomBeats - QuietBeats) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (growing && mirror.held() == cal_pkg::Capacity && $urandom_range(0, 7) == 0) begin
        growing = 1'b0;
      end else if (!growing && mirror.held() == 0 && $urandom_range(0, 3) == 0) begin
        growing = 1'b1;
      end
      send_beat(pick_op(growing), pick_value(), pick_index());
    end
    in_valid_i <= 1'b0;

    // Let every pending result arrive, then give the block time to show any extra beat.
    while (mirror.awaiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mirror.faults == 0) begin
      $display("cursor_array_list_core_tb passed");
    end else begin
      $display("cursor_array_list_core_tb failed");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("cursor_array_list_core_tb failed");
    $finish;
  end
endmodule
